>>> sv/psd_pkg.sv
package psd_pkg;

   localparam int unsigned MAX_VALUE_BYTES = 64;
   localparam int unsigned BUF_AW = (MAX_VALUE_BYTES > 1) ? $clog2(MAX_VALUE_BYTES) : 1;
   localparam int unsigned LEN_W = 7;
   localparam int unsigned POS_W = 6;
   localparam int unsigned ROW_W = 32;
   localparam int unsigned CSR_AW = 3;
   localparam int unsigned CSR_DW = 32;

   localparam logic [ROW_W-1:0] ROW_STRIDE_RST = 32'd16;
   localparam logic REG_ROW_STRIDE = 1'b0;

   localparam logic FUNC_DATA    = 1'b0;
   localparam logic FUNC_RESTART = 1'b1;

   typedef enum logic [1:0] {
      ST_PREFIX,
      ST_SUFFIX,
      ST_DATA,
      ST_EMIT
   } psd_state_type;

   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_PREFIX,
      ERR_CAPACITY
   } psd_err_type;

endpackage

>>> sv/psd_ram.sv
module psd_ram #(
   parameter int unsigned DEPTH = psd_pkg::MAX_VALUE_BYTES,
   parameter int unsigned WIDTH = 8
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/prefix_string_decoder.sv
// Response: a request that yields a byte, marker or error shows it on rsp in the following cycle.
// Prefix replay: the last suffix-length header byte is followed by prefix_length results
// from the string buffer, one per cycle while rsp is not stalled, each behind a registered buffer read.
// Throughput: one request per cycle while rsp is not stalled; the last header byte holds req_ready
// low while the buffer RAM read port replays the prefix.
// Reset: synchronous; clears control and row state, the row stride returns to 16.
module prefix_string_decoder (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_func,
   input  logic [7:0]                        req_data_byte,
   input  logic [23:0]                       req_restart_index,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_byte_valid,
   output logic [psd_pkg::POS_W-1:0]         rsp_byte_position,
   output logic [psd_pkg::LEN_W-1:0]         rsp_entry_length,
   output logic [psd_pkg::ROW_W-1:0]         rsp_row_index,
   output logic                              rsp_last,
   output logic [1:0]                        rsp_error_code,

   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [psd_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [psd_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [psd_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                              csr_pready
);

   localparam int unsigned AW = psd_pkg::BUF_AW;
   localparam int unsigned LW = psd_pkg::LEN_W;
   localparam int unsigned RW = psd_pkg::ROW_W;

   psd_pkg::psd_state_type state_ff, state_in;
   logic [1:0]             hdr_cnt_ff, hdr_cnt_in;
   logic [31:0]            prefix_ff, prefix_in;
   logic [31:0]            suffix_ff, suffix_in;
   logic [LW-1:0]          wp_ff, wp_in;
   logic [LW-1:0]          vlen_ff, vlen_in;
   logic [LW-1:0]          full_ff, full_in;
   logic [RW-1:0]          row_ff, row_in;
   logic                   err_ff, err_in;
   logic [RW-1:0]          interval_ff, interval_in;

   logic [LW-1:0]          issue_ff, issue_in;
   logic                   fetch_v_ff, fetch_v_in;
   logic [LW-1:0]          fetch_pos_ff, fetch_pos_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_byte_ff, rsp_byte_in;
   logic                   rsp_bvalid_ff, rsp_bvalid_in;
   logic [psd_pkg::POS_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic [LW-1:0]          rsp_len_ff, rsp_len_in;
   logic [RW-1:0]          rsp_row_ff, rsp_row_in;
   logic                   rsp_last_ff, rsp_last_in;
   psd_pkg::psd_err_type   rsp_err_ff, rsp_err_in;
   logic                   rsp_load;

   logic                   req_fire;
   logic                   rsp_free;
   logic                   csr_wr;
   logic [31:0]            byte_sh;
   logic [31:0]            suffix_full;
   logic [32:0]            sum_full;
   logic                   pfx_err;
   logic                   cap_err;
   logic [LW-1:0]          data_len;
   logic                   fetch_move;
   logic                   issue;

   logic                   mem_we;
   logic                   mem_re;
   logic [7:0]             mem_rdata;

   psd_ram #(
      .DEPTH (psd_pkg::MAX_VALUE_BYTES),
      .WIDTH (8)
   ) u_buf (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wp_ff[AW-1:0]),
      .wr_data (req_data_byte),
      .rd_en   (mem_re),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (mem_rdata)
   );

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite & csr_pready &
                   (csr_paddr[2] == psd_pkg::REG_ROW_STRIDE);
   assign csr_prdata = (csr_paddr[2] == psd_pkg::REG_ROW_STRIDE) ? interval_ff : '0;
   assign interval_in = csr_wr ? csr_pwdata : interval_ff;

   assign rsp_free  = !rsp_valid_ff | rsp_ready;
   assign req_ready = (state_ff != psd_pkg::ST_EMIT) & rsp_free;
   assign req_fire  = req_valid & req_ready;

   assign byte_sh     = 32'(req_data_byte) << {hdr_cnt_ff, 3'b000};
   assign suffix_full = suffix_ff | byte_sh;
   assign sum_full    = {1'b0, prefix_ff} + {1'b0, suffix_full};
   assign pfx_err     = prefix_ff > 32'(vlen_ff);
   assign cap_err     = sum_full > 33'(psd_pkg::MAX_VALUE_BYTES);
   assign data_len    = wp_ff + suffix_ff[LW-1:0];

   assign fetch_move = fetch_v_ff & rsp_free;
   assign issue      = (state_ff == psd_pkg::ST_EMIT) & (issue_ff < prefix_ff[LW-1:0]) &
                       (!fetch_v_ff | fetch_move);

   always_comb begin
      state_in     = state_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      prefix_in    = prefix_ff;
      suffix_in    = suffix_ff;
      wp_in        = wp_ff;
      vlen_in      = vlen_ff;
      full_in      = full_ff;
      row_in       = row_ff;
      err_in       = err_ff;
      issue_in     = issue_ff;
      fetch_pos_in = fetch_pos_ff;
      fetch_v_in   = issue | (fetch_v_ff & !fetch_move);
      mem_we       = 1'b0;
      mem_re       = issue;
      rsp_load     = 1'b0;
      rsp_byte_in  = rsp_byte_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;

      if (issue) begin
         issue_in     = issue_ff + LW'(1);
         fetch_pos_in = issue_ff;
      end

      if (fetch_move) begin
         rsp_load      = 1'b1;
         rsp_byte_in   = mem_rdata;
         rsp_bvalid_in = 1'b1;
         rsp_pos_in    = fetch_pos_ff[psd_pkg::POS_W-1:0];
         rsp_len_in    = full_ff;
         rsp_row_in    = row_ff;
         rsp_last_in   = (fetch_pos_ff + LW'(1)) == full_ff;
         rsp_err_in    = psd_pkg::ERR_NONE;
         if ((fetch_pos_ff + LW'(1)) == prefix_ff[LW-1:0]) begin
            if (suffix_ff == '0) begin
               vlen_in    = full_ff;
               row_in     = row_ff + RW'(1);
               state_in   = psd_pkg::ST_PREFIX;
               hdr_cnt_in = '0;
               prefix_in  = '0;
               wp_in      = '0;
            end else begin
               wp_in    = prefix_ff[LW-1:0];
               state_in = psd_pkg::ST_DATA;
            end
         end
      end

      if (req_fire) begin
         if (req_func == psd_pkg::FUNC_RESTART) begin
            state_in   = psd_pkg::ST_PREFIX;
            hdr_cnt_in = '0;
            prefix_in  = '0;
            suffix_in  = '0;
            wp_in      = '0;
            vlen_in    = '0;
            row_in     = RW'({8'b0, req_restart_index} * interval_ff);
            err_in     = 1'b0;
         end else if (!err_ff) begin
            unique case (state_ff)
               psd_pkg::ST_DATA: begin
                  mem_we        = 1'b1;
                  rsp_load      = 1'b1;
                  rsp_byte_in   = req_data_byte;
                  rsp_bvalid_in = 1'b1;
                  rsp_pos_in    = wp_ff[psd_pkg::POS_W-1:0];
                  rsp_len_in    = data_len;
                  rsp_row_in    = row_ff;
                  rsp_last_in   = suffix_ff == 32'd1;
                  rsp_err_in    = psd_pkg::ERR_NONE;
                  if (suffix_ff <= 32'd1) begin
                     vlen_in    = data_len;
                     row_in     = row_ff + RW'(1);
                     state_in   = psd_pkg::ST_PREFIX;
                     hdr_cnt_in = '0;
                     prefix_in  = '0;
                     suffix_in  = '0;
                     wp_in      = '0;
                  end else begin
                     suffix_in = suffix_ff - 32'd1;
                     wp_in     = wp_ff + LW'(1);
                  end
               end
               psd_pkg::ST_SUFFIX: begin
                  suffix_in = suffix_full;
                  if (hdr_cnt_ff != 2'd3) begin
                     hdr_cnt_in = hdr_cnt_ff + 2'd1;
                  end else begin
                     hdr_cnt_in    = '0;
                     rsp_byte_in   = '0;
                     rsp_bvalid_in = 1'b0;
                     rsp_pos_in    = '0;
                     rsp_len_in    = '0;
                     rsp_row_in    = row_ff;
                     rsp_last_in   = 1'b1;
                     rsp_err_in    = psd_pkg::ERR_NONE;
                     if (pfx_err || cap_err) begin
                        rsp_load   = 1'b1;
                        rsp_err_in = pfx_err ? psd_pkg::ERR_PREFIX : psd_pkg::ERR_CAPACITY;
                        err_in     = 1'b1;
                        state_in   = psd_pkg::ST_PREFIX;
                     end else if (sum_full == '0) begin
                        rsp_load  = 1'b1;
                        vlen_in   = '0;
                        row_in    = row_ff + RW'(1);
                        state_in  = psd_pkg::ST_PREFIX;
                        prefix_in = '0;
                        suffix_in = '0;
                        wp_in     = '0;
                     end else if (prefix_ff == '0) begin
                        wp_in    = '0;
                        state_in = psd_pkg::ST_DATA;
                     end else begin
                        full_in    = sum_full[LW-1:0];
                        issue_in   = '0;
                        fetch_v_in = 1'b0;
                        state_in   = psd_pkg::ST_EMIT;
                     end
                  end
               end
               psd_pkg::ST_PREFIX, psd_pkg::ST_EMIT: begin
                  if (hdr_cnt_ff == 2'd0) begin
                     prefix_in = byte_sh;
                  end else begin
                     prefix_in = prefix_ff | byte_sh;
                  end
                  if (hdr_cnt_ff != 2'd3) begin
                     hdr_cnt_in = hdr_cnt_ff + 2'd1;
                  end else begin
                     hdr_cnt_in = '0;
                     suffix_in  = '0;
                     state_in   = psd_pkg::ST_SUFFIX;
                  end
               end
               default: begin
                  state_in = psd_pkg::ST_PREFIX;
               end
            endcase
         end
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psd_pkg::ST_PREFIX;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cnt_ff   <= '0;
         prefix_ff    <= '0;
         suffix_ff    <= '0;
         wp_ff        <= '0;
         vlen_ff      <= '0;
         row_ff       <= '0;
         err_ff       <= 1'b0;
         interval_ff  <= psd_pkg::ROW_STRIDE_RST;
         issue_ff     <= '0;
         fetch_v_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hdr_cnt_ff   <= hdr_cnt_in;
         prefix_ff    <= prefix_in;
         suffix_ff    <= suffix_in;
         wp_ff        <= wp_in;
         vlen_ff      <= vlen_in;
         row_ff       <= row_in;
         err_ff       <= err_in;
         interval_ff  <= interval_in;
         issue_ff     <= issue_in;
         fetch_v_ff   <= fetch_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      full_ff       <= full_in;
      fetch_pos_ff  <= fetch_pos_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_err_ff    <= rsp_err_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_byte_valid    = rsp_bvalid_ff;
   assign rsp_byte_position = rsp_pos_ff;
   assign rsp_entry_length  = rsp_len_ff;
   assign rsp_row_index     = rsp_row_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_error_code    = rsp_err_ff;

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_func == psd_pkg::FUNC_RESTART) |=>
         (state_ff == psd_pkg::ST_PREFIX && !err_ff && wp_ff == '0))
      else $error("restart did not clear decoder state");

   a_fetch_in_emit: assert property (@(posedge clock) disable iff (reset)
      fetch_v_ff |-> (state_ff == psd_pkg::ST_EMIT))
      else $error("buffer fetch pending outside prefix replay");

   a_data_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == psd_pkg::ST_DATA) |->
         (suffix_ff != '0 && data_len <= LW'(psd_pkg::MAX_VALUE_BYTES)))
      else $error("suffix write runs past buffer capacity");

   a_vlen_bound: assert property (@(posedge clock) disable iff (reset)
      vlen_ff <= LW'(psd_pkg::MAX_VALUE_BYTES))
      else $error("stored string length over capacity");

   a_emit_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == psd_pkg::ST_EMIT) |-> (issue_ff <= prefix_ff[LW-1:0]))
      else $error("prefix replay read beyond prefix length");

endmodule
